@@ rtl/core/ipv4_ddp_pkg.sv @@
// Shared types and constants for the dotted-decimal IPv4 parser.
`default_nettype none

package ipv4_ddp_pkg;

  localparam logic [7:0] CharEnd   = 8'h00;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam int unsigned GroupW   = 9;
  localparam logic [GroupW-1:0] GroupMax = 9'd255;
  localparam logic [GroupW-1:0] GroupSat = 9'd256;
  localparam logic [1:0] MaxDots  = 2'd3;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    CLS_DIGIT = 2'd0,
    CLS_DOT   = 2'd1,
    CLS_END   = 2'd2,
    CLS_OTHER = 2'd3
  } char_cls_e;

  typedef struct packed {
    char_cls_e  cls;
    logic [3:0] digit;
  } char_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

@@ rtl/core/ipv4_ddp_front.sv @@
// Front end: accepts characters and registers their class and digit value.
`default_nettype none

module ipv4_ddp_front
  import ipv4_ddp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [7:0] character_i,
  output      logic       item_valid_o,
  input  wire logic       item_ready_i,
  output      char_item_t item_o
);

  logic       valid_q, valid_d;
  char_item_t item_q, item_d;
  logic       take;
  logic [7:0] digit_off;

  assign in_ready_o = !valid_q || item_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign digit_off  = character_i - CharZero;

  always_comb begin
    item_d.digit = digit_off[3:0];
    priority if (character_i == CharEnd) begin
      item_d.cls = CLS_END;
    end else if (character_i == CharDot) begin
      item_d.cls = CLS_DOT;
    end else if (character_i >= CharZero && character_i <= CharNine) begin
      item_d.cls = CLS_DIGIT;
    end else begin
      item_d.cls = CLS_OTHER;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

@@ rtl/core/ipv4_ddp_queue.sv @@
// Short queue of classified characters between front and back end.
`default_nettype none

module ipv4_ddp_queue
  import ipv4_ddp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_valid_i,
  output      logic    push_ready_o,
  input  wire char_item_t push_item_i,
  output      logic    pop_valid_o,
  input  wire logic    pop_ready_i,
  output      char_item_t pop_item_o,
  output      queue_status_t status_o
);

  char_item_t           mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 push, pop;

  assign status_o.full  = (count_q == QueueCntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign push_ready_o   = !status_o.full;
  assign pop_valid_o    = !status_o.empty;
  assign push           = push_valid_i && push_ready_o;
  assign pop            = pop_valid_o && pop_ready_i;
  assign pop_item_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ipv4_ddp_back.sv @@
// Back end: group accumulation, dot handling and the result register.
`default_nettype none

module ipv4_ddp_back
  import ipv4_ddp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        item_valid_i,
  output      logic        item_ready_o,
  input  wire char_item_t  item_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic        valid_res_o,
  output      logic [31:0] address_o
);

  logic [GroupW-1:0] group_q, group_d;
  logic [23:0]       addr_q, addr_d;
  logic [1:0]        dots_q, dots_d;
  logic              err_q, err_d;
  logic              out_valid_q, out_valid_d;
  logic              res_q, res_d;
  logic [31:0]       address_q, address_d;
  logic              pop;
  logic [11:0]       group_x10;
  logic [11:0]       group_new;
  logic [31:0]       final_addr;
  logic              final_ok;

  assign item_ready_o = (item_i.cls != CLS_END) || !out_valid_q || out_ready_i;
  assign pop          = item_valid_i && item_ready_o;

  // group*10 as shifts; the group never exceeds 256 so 12 bits suffice
  assign group_x10 = {group_q, 3'b000} + {2'b00, group_q, 1'b0};
  assign group_new = group_x10 + {8'd0, item_i.digit};

  assign final_ok = !err_q && (group_q <= GroupMax);

  always_comb begin
    unique case (dots_q)
      2'd0:    final_addr = {group_q[7:0], 24'd0};
      2'd1:    final_addr = {addr_q[7:0], group_q[7:0], 16'd0};
      2'd2:    final_addr = {addr_q[15:0], group_q[7:0], 8'd0};
      default: final_addr = {addr_q[23:0], group_q[7:0]};
    endcase
  end

  always_comb begin
    group_d     = group_q;
    addr_d      = addr_q;
    dots_d      = dots_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_d       = res_q;
    address_d   = address_q;
    if (pop) begin
      if (item_i.cls == CLS_END) begin
        out_valid_d = 1'b1;
        res_d       = final_ok;
        address_d   = final_ok ? final_addr : 32'd0;
        group_d     = '0;
        addr_d      = '0;
        dots_d      = '0;
        err_d       = 1'b0;
      end else if (!err_q) begin
        unique case (item_i.cls)
          CLS_DIGIT: begin
            group_d = (group_new > {3'd0, GroupSat}) ? GroupSat : group_new[GroupW-1:0];
          end
          CLS_DOT: begin
            if (dots_q == MaxDots || group_q > GroupMax) begin
              err_d = 1'b1;
            end else begin
              addr_d  = {addr_q[15:0], group_q[7:0]};
              group_d = '0;
              dots_d  = dots_q + 2'd1;
            end
          end
          default: err_d = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q     <= '0;
      addr_q      <= '0;
      dots_q      <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      group_q     <= group_d;
      addr_q      <= addr_d;
      dots_q      <= dots_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    address_q <= address_d;
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = res_q;
  assign address_o   = address_q;

endmodule

`default_nettype wire

@@ rtl/core/ipv4_dotted_decimal_parser.sv @@
// A terminator's result passes through the front register, the queue and the result register;
// other characters give no result.
// Throughput: one character per cycle, except while a terminator waits for a result to be taken.
// The result register lets a new character other than a terminator in while a result waits to be taken.
// Reset (rst_ni low, asynchronous) empties front register, queue and result, clears parser state.
`default_nettype none

module ipv4_dotted_decimal_parser
  import ipv4_ddp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [7:0]  character_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic        valid_res_o,
  output      logic [31:0] address_o
);

  logic          fr_valid, fr_ready;
  char_item_t    fr_item;
  logic          bk_valid, bk_ready;
  char_item_t    bk_item;
  queue_status_t q_status;

  ipv4_ddp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .character_i  (character_i),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  ipv4_ddp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_item_o   (bk_item),
    .status_o     (q_status)
  );

  ipv4_ddp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (bk_valid),
    .item_ready_o (bk_ready),
    .item_i       (bk_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .valid_res_o  (valid_res_o),
    .address_o    (address_o)
  );

  // an invalid string always reports address zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (address_o == 32'd0))
    else $error("invalid result with non-zero address");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue both full and empty");

  // back end must never see an item while the queue is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.empty |-> !bk_valid)
    else $error("back end offered an item from an empty queue");

  // a full queue holds the front register's item back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_status.full && fr_valid) |=> fr_valid)
    else $error("front item lost while queue full");

endmodule

`default_nettype wire
